/* rtl/core/nearest_neighbor_image_rotate_assert.svh */
// assertion macros used by the rotation core controller
`ifndef NEAREST_NEIGHBOR_IMAGE_ROTATE_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_ROTATE_ASSERT_SVH

// property checked on every clock edge outside reset
`define NNIR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("nnir assertion failed");

// property checked on every clock edge, reset included
`define NNIR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("nnir assertion failed");

`endif

/* rtl/core/nnir_pkg.sv */
// types, constants and codes of the rotation core
package nnir_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);

	localparam int COORD_W = 8;
	localparam int PIX_W   = 8;
	localparam int DIM_W   = 9;
	localparam int TRIG_W  = 16;
	localparam int FRAC_W  = 14;
	localparam int SHIFT_W = FRAC_W + 1;
	localparam int OFS_W   = DIM_W + 2;
	localparam int PROD_W  = OFS_W + TRIG_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int POS_W   = ACC_W - SHIFT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);
	localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << SHIFT_W) - 1);

	localparam logic [DIM_W-1:0]         RST_WIDTH  = DIM_W'(256);
	localparam logic [DIM_W-1:0]         RST_HEIGHT = DIM_W'(256);
	localparam logic signed [TRIG_W-1:0] RST_SIN    = TRIG_W'(0);
	localparam logic signed [TRIG_W-1:0] RST_COS    = TRIG_W'(16384);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_SIN    = 2'd2,
		CFG_COS    = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_LOOK,
		ST_FETCH
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic sum;
		logic look;
		logic load;
	} cmd_t;

endpackage

/* rtl/core/nnir_if.sv */
// channel interfaces: request, response and register write
interface nnir_req_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [nnir_pkg::COORD_W-1:0]      coord_x;
	logic [nnir_pkg::COORD_W-1:0]      coord_y;
	logic [nnir_pkg::PIX_W-1:0]        pixel_in;

	modport source (output valid, opcode, coord_x, coord_y, pixel_in, input ready);
	modport sink (input valid, opcode, coord_x, coord_y, pixel_in, output ready);
endinterface

interface nnir_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [nnir_pkg::PIX_W-1:0]        pixel_out;
	logic                              in_frame;

	modport source (output valid, pixel_out, in_frame, input ready);
	modport sink (input valid, pixel_out, in_frame, output ready);
endinterface

interface nnir_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [nnir_pkg::CFG_IDX_W-1:0]    index;
	logic [nnir_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/nnir_ctrl.sv */
// controller state machine of the rotation core
`include "nearest_neighbor_image_rotate_assert.svh"

module nnir_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_opcode,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	output nnir_pkg::cmd_t     cmd
);

	nnir_pkg::state_t state_q;
	nnir_pkg::state_t state_d;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nnir_pkg::ST_IDLE: begin
				if (accept && in_opcode == nnir_pkg::OP_READ) begin
					state_d = nnir_pkg::ST_MUL;
				end
			end
			nnir_pkg::ST_MUL:  state_d = nnir_pkg::ST_SUM;
			nnir_pkg::ST_SUM:  state_d = nnir_pkg::ST_LOOK;
			nnir_pkg::ST_LOOK: state_d = nnir_pkg::ST_FETCH;
			nnir_pkg::ST_FETCH: begin
				if (out_free) begin
					state_d = nnir_pkg::ST_IDLE;
				end
			end
			default: state_d = nnir_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			nnir_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			nnir_pkg::ST_MUL:   cmd.mul  = 1'b1;
			nnir_pkg::ST_SUM:   cmd.sum  = 1'b1;
			nnir_pkg::ST_LOOK:  cmd.look = 1'b1;
			nnir_pkg::ST_FETCH: cmd.load = out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nnir_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`NNIR_ASSERT(a_read_starts_math, clk, arst_n,
		(accept && in_opcode == nnir_pkg::OP_READ) |=> state_q == nnir_pkg::ST_MUL)
	`NNIR_ASSERT(a_write_stays_idle, clk, arst_n,
		(accept && in_opcode == nnir_pkg::OP_WRITE) |=> state_q == nnir_pkg::ST_IDLE)
	`NNIR_ASSERT(a_math_sequence, clk, arst_n,
		state_q == nnir_pkg::ST_MUL |=> state_q == nnir_pkg::ST_SUM
			##1 state_q == nnir_pkg::ST_LOOK ##1 state_q == nnir_pkg::ST_FETCH)
	`NNIR_ASSERT(a_fetch_delivers, clk, arst_n,
		(state_q == nnir_pkg::ST_FETCH && out_free)
			|=> (out_valid_q && state_q == nnir_pkg::ST_IDLE))
	`NNIR_ASSERT_ALWAYS(a_load_only_when_free, clk,
		!(cmd.load && out_valid_q && !out_ready))

endmodule

/* rtl/core/nnir_datapath.sv */
// datapath: registers, coordinate arithmetic, frame store, result register
module nnir_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nnir_pkg::cmd_t                     cmd,
	input  logic                               in_opcode,
	input  logic [nnir_pkg::COORD_W-1:0]       in_x,
	input  logic [nnir_pkg::COORD_W-1:0]       in_y,
	input  logic [nnir_pkg::PIX_W-1:0]         in_pixel,
	input  logic                               cfg_we,
	input  logic [nnir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nnir_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [nnir_pkg::PIX_W-1:0]         pixel_out,
	output logic                               in_frame
);

	logic [nnir_pkg::DIM_W-1:0]          width_q;
	logic [nnir_pkg::DIM_W-1:0]          height_q;
	logic signed [nnir_pkg::TRIG_W-1:0]  sin_q;
	logic signed [nnir_pkg::TRIG_W-1:0]  cos_q;

	logic [nnir_pkg::DIM_W-1:0]          eff_w;
	logic [nnir_pkg::DIM_W-1:0]          eff_h;
	logic                                in_inside;

	logic [nnir_pkg::COORD_W-1:0]        x_q;
	logic [nnir_pkg::COORD_W-1:0]        y_q;
	logic [nnir_pkg::DIM_W-1:0]          w_q;
	logic [nnir_pkg::DIM_W-1:0]          h_q;
	logic                                dest_in_q;

	logic signed [nnir_pkg::OFS_W-1:0]   dx2;
	logic signed [nnir_pkg::OFS_W-1:0]   dy2;
	logic signed [nnir_pkg::PROD_W-1:0]  dxc_s1;
	logic signed [nnir_pkg::PROD_W-1:0]  dys_s1;
	logic signed [nnir_pkg::PROD_W-1:0]  dyc_s1;
	logic signed [nnir_pkg::PROD_W-1:0]  dxs_s1;

	logic signed [nnir_pkg::ACC_W-1:0]   wc;
	logic signed [nnir_pkg::ACC_W-1:0]   hc;
	logic signed [nnir_pkg::ACC_W-1:0]   sxq_s2;
	logic signed [nnir_pkg::ACC_W-1:0]   syq_s2;

	logic signed [nnir_pkg::ACC_W-1:0]   sxt;
	logic signed [nnir_pkg::ACC_W-1:0]   syt;
	logic signed [nnir_pkg::POS_W-1:0]   sx;
	logic signed [nnir_pkg::POS_W-1:0]   sy;
	logic                                src_in;
	logic [nnir_pkg::ADDR_W-1:0]         rd_addr;
	logic [nnir_pkg::ADDR_W-1:0]         wr_addr;

	logic [nnir_pkg::PIX_W-1:0]          rd_data_s3;
	logic                                hit_s3;
	logic [nnir_pkg::PIX_W-1:0]          pixel_out_q;
	logic                                in_frame_q;

	logic [nnir_pkg::PIX_W-1:0]          frame_mem [nnir_pkg::DEPTH];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nnir_pkg::RST_WIDTH;
			height_q <= nnir_pkg::RST_HEIGHT;
			sin_q    <= nnir_pkg::RST_SIN;
			cos_q    <= nnir_pkg::RST_COS;
		end else if (cfg_we) begin
			unique case (nnir_pkg::cfg_idx_t'(cfg_index))
				nnir_pkg::CFG_WIDTH:  width_q  <= cfg_data[nnir_pkg::DIM_W-1:0];
				nnir_pkg::CFG_HEIGHT: height_q <= cfg_data[nnir_pkg::DIM_W-1:0];
				nnir_pkg::CFG_SIN:    sin_q    <= $signed(cfg_data);
				nnir_pkg::CFG_COS:    cos_q    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// sizes saturate at the store dimensions
	assign eff_w = (width_q > nnir_pkg::MAX_W_D) ? nnir_pkg::MAX_W_D : width_q;
	assign eff_h = (height_q > nnir_pkg::MAX_H_D) ? nnir_pkg::MAX_H_D : height_q;
	assign in_inside = ({1'b0, in_x} < eff_w) && ({1'b0, in_y} < eff_h);
	assign wr_addr   = nnir_pkg::ADDR_W'({in_y, in_x});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q       <= in_x;
			y_q       <= in_y;
			w_q       <= eff_w;
			h_q       <= eff_h;
			dest_in_q <= in_inside;
		end
	end

	// doubled offsets from the center
	assign dx2 = $signed({2'b00, x_q, 1'b0}) - $signed({2'b00, w_q});
	assign dy2 = $signed({2'b00, y_q, 1'b0}) - $signed({2'b00, h_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			dxc_s1 <= nnir_pkg::PROD_W'(dx2) * nnir_pkg::PROD_W'(cos_q);
			dys_s1 <= nnir_pkg::PROD_W'(dy2) * nnir_pkg::PROD_W'(sin_q);
			dyc_s1 <= nnir_pkg::PROD_W'(dy2) * nnir_pkg::PROD_W'(cos_q);
			dxs_s1 <= nnir_pkg::PROD_W'(dx2) * nnir_pkg::PROD_W'(sin_q);
		end
	end

	// center in q.15 of doubled offsets
	assign wc = nnir_pkg::ACC_W'($signed({1'b0, w_q, {nnir_pkg::FRAC_W{1'b0}}}));
	assign hc = nnir_pkg::ACC_W'($signed({1'b0, h_q, {nnir_pkg::FRAC_W{1'b0}}}));

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sxq_s2 <= nnir_pkg::ACC_W'(dxc_s1) + nnir_pkg::ACC_W'(dys_s1) + wc;
			syq_s2 <= nnir_pkg::ACC_W'(dyc_s1) - nnir_pkg::ACC_W'(dxs_s1) + hc;
		end
	end

	// truncate toward zero
	assign sxt = sxq_s2 + (sxq_s2[nnir_pkg::ACC_W-1] ? nnir_pkg::TRUNC_BIAS : '0);
	assign syt = syq_s2 + (syq_s2[nnir_pkg::ACC_W-1] ? nnir_pkg::TRUNC_BIAS : '0);
	assign sx  = sxt[nnir_pkg::ACC_W-1:nnir_pkg::SHIFT_W];
	assign sy  = syt[nnir_pkg::ACC_W-1:nnir_pkg::SHIFT_W];

	assign src_in = !sx[nnir_pkg::POS_W-1] && !sy[nnir_pkg::POS_W-1]
		&& (sx < $signed(nnir_pkg::POS_W'(w_q)))
		&& (sy < $signed(nnir_pkg::POS_W'(h_q)));
	assign rd_addr = nnir_pkg::ADDR_W'({sy[nnir_pkg::COORD_W-1:0], sx[nnir_pkg::COORD_W-1:0]});

	// frame store
	always_ff @(posedge clk) begin
		if (cmd.capture && in_opcode == nnir_pkg::OP_WRITE && in_inside) begin
			frame_mem[wr_addr] <= in_pixel;
		end
		if (cmd.look) begin
			rd_data_s3 <= frame_mem[rd_addr];
			hit_s3     <= dest_in_q && src_in;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_out_q <= hit_s3 ? rd_data_s3 : '0;
			in_frame_q  <= hit_s3;
		end
	end

	assign pixel_out = pixel_out_q;
	assign in_frame  = in_frame_q;

endmodule

/* rtl/core/nearest_neighbor_image_rotate.sv */
// top level of the nearest-neighbor frame rotation core
// A write beat stores one source pixel in the on-chip 256x256 frame store;
// writes outside the configured frame are dropped, and writes never give a
// response. A read beat runs through four controller steps after acceptance:
// the four products, the two Q.15 sums, the truncation with the frame-store
// read on its single read port, and the load of the result register. Its
// result becomes valid as the controller returns to idle and can take the next
// request. One item is in flight at a time; a read blocks new beats
// until its result reaches the output register, while a result waiting there does
// not block the next request. A later read whose result register is still full
// waits in its last step until the waiting result is taken. Frame contents are
// undefined until written, so no clearing pass runs after reset. Register writes
// are always ready and must be issued only while the core is idle.
module nearest_neighbor_image_rotate (
	input  logic        clk,
	input  logic        arst_n,
	nnir_req_if.sink    req,
	nnir_rsp_if.source  rsp,
	nnir_cfg_if.sink    cfg
);

	nnir_pkg::cmd_t cmd;
	logic           req_ready;
	logic           rsp_valid;

	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

	nnir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req_ready),
		.out_ready (rsp.ready),
		.out_valid (rsp_valid),
		.cmd       (cmd)
	);

	nnir_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_opcode (req.opcode),
		.in_x      (req.coord_x),
		.in_y      (req.coord_y),
		.in_pixel  (req.pixel_in),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.pixel_out (rsp.pixel_out),
		.in_frame  (rsp.in_frame)
	);

endmodule
